[design/sha1h_pkg.sv]
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types, codes and constants for the SHA-1 stream hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

	localparam int BLOCK_BYTES = 64;
	localparam int SCHED_WORDS = 16;
	localparam int HASH_WORDS  = 5;
	localparam int ROUNDS      = 80;
	localparam int POS_W       = 6;
	localparam int RND_W       = 7;
	localparam int IDX_W       = 3;
	localparam int CNT_W       = 64;

	localparam logic [1:0] MODE_ABSORB  = 2'd0;
	localparam logic [1:0] MODE_FINISH  = 2'd1;
	localparam logic [1:0] MODE_PARTIAL = 2'd2;

	localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(HASH_WORDS - 1);
	localparam logic [RND_W-1:0] LAST_RND  = RND_W'(ROUNDS - 1);

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] K_ROUND [4] = '{
		32'h5a827999, 32'h6ed9eba1, 32'h8f1bbcdc, 32'hca62c1d6
	};

	localparam logic [31:0] H_INIT [HASH_WORDS] = '{
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		JOB_BLOCK,
		JOB_PAD,
		JOB_LEN
	} job_t;

	typedef enum logic [1:0] {
		BLK_FULL,
		BLK_PAD,
		BLK_LEN
	} blk_sel_t;

	typedef struct packed {
		logic             absorb;
		logic             load;
		blk_sel_t         blk_sel;
		logic             base_dig;
		logic             dig_copy;
		logic             round;
		logic [RND_W-1:0] rnd;
		logic             add_h;
		logic             add_dig;
		logic             shift_out;
		logic             clear;
	} dp_cmd_t;

	typedef struct packed {
		logic pos_last;
		logic pos_ge56;
	} dp_stat_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

[design/sha1_stream_hasher.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher
// SHA-1 digest of a byte stream with finish and digest-so-far requests.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                                 | tuser     | tlast
//  s_axis   | in        | [7:0] data_byte                       | [1:0] mode | -
//  m_axis   | out       | [31:0] digest_word, [34:32] word_index | -         | last
//
//  An absorb byte is taken while idle; the byte that fills a block starts a
//  compression (schedule load, 80 rounds on the single round unit, chaining add).
//  Finish and digest-so-far compress the padding block, and a second block when
//  the padding needs one, then give five output words at one per accepted cycle.
//  Reset restores the initial chaining value and clears position and count.
//  Input is held off while a block compresses or digest words are pending.
// ----------------------------------------------------------------------------
module sha1_stream_hasher
	import sha1h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index
	output logic        m_tlast
);

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic [IDX_W-1:0] word_index;
	logic [31:0]      digest_word;

	sha1h_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_mode   (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_idx   (word_index),
		.out_last  (m_tlast),
		.stat      (stat),
		.cmd       (cmd)
	);

	sha1h_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (s_tdata),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (digest_word)
	);

	assign m_tdata = {5'b0, word_index, digest_word};

endmodule

[design/sha1h_ctrl.sv]
// ----------------------------------------------------------------------------
// sha1h_ctrl
// Sequencer: byte intake, compression rounds, padding blocks, digest output.
// ----------------------------------------------------------------------------
module sha1h_ctrl
	import sha1h_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [1:0]       in_mode,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [IDX_W-1:0] out_idx,
	output logic             out_last,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd
);

	state_t           state_q, state_d;
	job_t             job_q, job_d;
	logic             fin_q, fin_d;
	logic [RND_W-1:0] rnd_q, rnd_d;
	logic [IDX_W-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			job_q   <= JOB_BLOCK;
			fin_q   <= 1'b0;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			job_q   <= job_d;
			fin_q   <= fin_d;
			rnd_q   <= rnd_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		job_d     = job_q;
		fin_d     = fin_q;
		rnd_d     = rnd_q;
		idx_d     = idx_q;
		cmd       = '0;
		cmd.rnd   = rnd_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_mode)
						MODE_ABSORB: begin
							cmd.absorb = 1'b1;
							if (stat.pos_last) begin
								job_d   = JOB_BLOCK;
								state_d = ST_LOAD;
							end
						end
						MODE_FINISH, MODE_PARTIAL: begin
							job_d   = JOB_PAD;
							fin_d   = (in_mode == MODE_FINISH);
							state_d = ST_LOAD;
						end
						default: ;
					endcase
				end
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				case (job_q)
					JOB_PAD: cmd.blk_sel = BLK_PAD;
					JOB_LEN: cmd.blk_sel = BLK_LEN;
					default: cmd.blk_sel = BLK_FULL;
				endcase
				cmd.base_dig = (job_q == JOB_LEN);
				cmd.dig_copy = (job_q == JOB_PAD);
				rnd_d        = '0;
				state_d      = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				if (rnd_q == LAST_RND) begin
					state_d = ST_ADD;
				end else begin
					rnd_d = rnd_q + 1'b1;
				end
			end
			ST_ADD: begin
				if (job_q == JOB_BLOCK) begin
					cmd.add_h = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					cmd.add_dig = 1'b1;
					if (job_q == JOB_PAD && stat.pos_ge56) begin
						job_d   = JOB_LEN;
						state_d = ST_LOAD;
					end else begin
						idx_d   = '0;
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.shift_out = 1'b1;
					if (idx_q == LAST_WORD) begin
						cmd.clear = fin_q;
						state_d   = ST_IDLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_idx  = idx_q;
	assign out_last = (idx_q == LAST_WORD);

endmodule

[design/sha1h_datapath.sv]
// ----------------------------------------------------------------------------
// sha1h_datapath
// Block buffer, padding, message schedule, round unit and chaining value.
// ----------------------------------------------------------------------------
module sha1h_datapath
	import sha1h_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output logic [31:0] digest_word
);

	logic [31:0]      buf_q [SCHED_WORDS];
	logic [POS_W-1:0] pos_q;
	logic [CNT_W-1:0] bitcnt_q;
	logic [31:0]      h_q   [HASH_WORDS];
	logic [31:0]      dig_q [HASH_WORDS];
	logic [31:0]      w_q   [SCHED_WORDS];
	logic [31:0]      a_q, b_q, c_q, d_q, e_q;

	logic [7:0]  buf_b [BLOCK_BYTES];
	logic [7:0]  len_b [8];
	logic [7:0]  blk_b [BLOCK_BYTES];
	logic [31:0] blk_w [SCHED_WORDS];
	logic [31:0] f, k, t, w_new;
	logic [31:0] base [HASH_WORDS];
	logic [31:0] sum  [HASH_WORDS];

	assign stat.pos_last = (pos_q == POS_W'(BLOCK_BYTES - 1));
	assign stat.pos_ge56 = (pos_q[POS_W-1:3] == 3'b111);

	always_comb begin
		for (int i = 0; i < SCHED_WORDS; i++) begin
			for (int b = 0; b < 4; b++) begin
				buf_b[4*i+b] = buf_q[i][8*(3-b) +: 8];
			end
		end
		for (int i = 0; i < 8; i++) begin
			len_b[i] = bitcnt_q[8*(7-i) +: 8];
		end
		for (int j = 0; j < BLOCK_BYTES; j++) begin
			case (cmd.blk_sel)
				BLK_FULL: blk_b[j] = buf_b[j];
				BLK_PAD: begin
					if (POS_W'(j) < pos_q) begin
						blk_b[j] = buf_b[j];
					end else if (POS_W'(j) == pos_q) begin
						blk_b[j] = PAD_BYTE;
					end else if (j >= 56 && !stat.pos_ge56) begin
						blk_b[j] = len_b[3'(j)];
					end else begin
						blk_b[j] = 8'h00;
					end
				end
				BLK_LEN: blk_b[j] = (j >= 56) ? len_b[3'(j)] : 8'h00;
				default: blk_b[j] = 8'h00;
			endcase
		end
		for (int i = 0; i < SCHED_WORDS; i++) begin
			blk_w[i] = {blk_b[4*i], blk_b[4*i+1], blk_b[4*i+2], blk_b[4*i+3]};
		end
	end

	always_comb begin
		if (cmd.rnd < RND_W'(20)) begin
			f = (b_q & c_q) | (d_q & ~b_q);
			k = K_ROUND[0];
		end else if (cmd.rnd < RND_W'(40)) begin
			f = b_q ^ c_q ^ d_q;
			k = K_ROUND[1];
		end else if (cmd.rnd < RND_W'(60)) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = K_ROUND[2];
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = K_ROUND[3];
		end
		t     = rotl(a_q, 5) + f + e_q + w_q[0] + k;
		w_new = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
		for (int i = 0; i < HASH_WORDS; i++) begin
			base[i] = cmd.base_dig ? dig_q[i] : h_q[i];
		end
		sum[0] = a_q;
		sum[1] = b_q;
		sum[2] = c_q;
		sum[3] = d_q;
		sum[4] = e_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.absorb) begin
			buf_q[pos_q[POS_W-1:2]][{~pos_q[1:0], 3'b000} +: 8] <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			bitcnt_q <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else begin
			if (cmd.clear) begin
				pos_q    <= '0;
				bitcnt_q <= '0;
				for (int i = 0; i < HASH_WORDS; i++) begin
					h_q[i] <= H_INIT[i];
				end
			end else begin
				if (cmd.absorb) begin
					pos_q    <= pos_q + 1'b1;
					bitcnt_q <= bitcnt_q + CNT_W'(8);
				end
				if (cmd.add_h) begin
					for (int i = 0; i < HASH_WORDS; i++) begin
						h_q[i] <= h_q[i] + sum[i];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int i = 0; i < SCHED_WORDS; i++) begin
				w_q[i] <= blk_w[i];
			end
			a_q <= base[0];
			b_q <= base[1];
			c_q <= base[2];
			d_q <= base[3];
			e_q <= base[4];
		end else if (cmd.round) begin
			for (int i = 0; i < SCHED_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[SCHED_WORDS-1] <= w_new;
			a_q <= t;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dig_copy) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				dig_q[i] <= h_q[i];
			end
		end else if (cmd.add_dig) begin
			for (int i = 0; i < HASH_WORDS; i++) begin
				dig_q[i] <= dig_q[i] + sum[i];
			end
		end else if (cmd.shift_out) begin
			for (int i = 0; i < HASH_WORDS - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
		end
	end

	assign digest_word = dig_q[0];

endmodule

[test/sha1_stream_hasher_tb.sv]
// ----------------------------------------------------------------------------
// sha1_stream_hasher_tb
// Self-checking bench for the SHA-1 stream hasher. Byte streams with finish
// and digest-so-far requests go in under random back-pressure; every digest
// word that comes out is checked against a SHA-1 predictor kept in the bench.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sha1h_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;
	localparam int TAIL_CYCLES = 200;
	localparam int RANDOM_ITEMS = 270;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       drain;
	} hash_req_t;

	typedef struct packed {
		logic [31:0]      word;
		logic [IDX_W-1:0] idx;
		logic             last;
	} digest_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	hash_req_t    req_q[$];
	digest_beat_t digest_q[$];
	hash_req_t    cur_req;

	logic [159:0] chain;
	logic [511:0] msg_blk;
	logic [5:0]   msg_pos;
	logic [63:0]  msg_bits;

	int err_count = 0;
	int total_reqs = 0;
	int reqs_done = 0;
	int beats_seen = 0;
	int idle_cycles = 0;
	int hold_cnt = 0;
	bit hold_done = 1'b0;

	sha1_stream_hasher u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [159:0] sha1_fold(input logic [159:0] h, input logic [511:0] blk);
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t, x;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = blk[511 - 32 * i -: 32];
		for (i = 16; i < 80; i++) begin
			x = w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16];
			w[i] = {x[30:0], x[31]};
		end
		{a, b, c, d, e} = h;
		for (i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (d & ~b);
				k = K_ROUND[0];
			end else if (i < 40) begin
				f = b ^ c ^ d;
				k = K_ROUND[1];
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_ROUND[2];
			end else begin
				f = b ^ c ^ d;
				k = K_ROUND[3];
			end
			t = {a[26:0], a[31:27]} + f + e + w[i] + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
	endfunction

	task automatic hash_reset();
		chain = {H_INIT[0], H_INIT[1], H_INIT[2], H_INIT[3], H_INIT[4]};
		msg_blk = '0;
		msg_pos = '0;
		msg_bits = '0;
	endtask

	task automatic hash_accept(input hash_req_t r);
		logic [511:0] blk;
		logic [159:0] dig;
		digest_beat_t beat;
		int p;
		int i;
		if (r.mode == MODE_ABSORB) begin
			msg_blk[511 - 8 * msg_pos -: 8] = r.data;
			msg_pos = msg_pos + 6'd1;
			if (msg_pos == '0)
				chain = sha1_fold(chain, msg_blk);
			msg_bits = msg_bits + 64'd8;
		end else if (r.mode != MODE_UNUSED) begin
			blk = msg_blk;
			dig = chain;
			p = msg_pos;
			blk[511 - 8 * p -: 8] = PAD_BYTE;
			p++;
			if (p > 56) begin
				for (i = p; i < 64; i++)
					blk[511 - 8 * i -: 8] = 8'h00;
				dig = sha1_fold(dig, blk);
				p = 0;
			end
			for (i = p; i < 56; i++)
				blk[511 - 8 * i -: 8] = 8'h00;
			blk[63:0] = msg_bits;
			dig = sha1_fold(dig, blk);
			for (i = 0; i < HASH_WORDS; i++) begin
				beat.word = dig[159 - 32 * i -: 32];
				beat.idx = IDX_W'(i);
				beat.last = (i == HASH_WORDS - 1);
				digest_q.push_back(beat);
			end
			if (r.mode == MODE_FINISH) begin
				chain = {H_INIT[0], H_INIT[1], H_INIT[2], H_INIT[3], H_INIT[4]};
				msg_pos = '0;
				msg_bits = '0;
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic int send_idle_pct();
		if (reqs_done < total_reqs / 3)
			return 16;
		if (reqs_done < 2 * total_reqs / 3)
			return 87;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (reqs_done < total_reqs / 3)
			return 87;
		if (reqs_done < 2 * total_reqs / 3)
			return 16;
		return 0;
	endfunction

	task automatic push_req(input logic [1:0] mode, input logic [7:0] data, input bit drain);
		hash_req_t r;
		r.mode = mode;
		r.data = data;
		r.drain = drain;
		req_q.push_back(r);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				hash_accept(cur_req);
				reqs_done++;
			end
			if (!s_tvalid || s_tready) begin
				if (req_q.size() > 0 && !(req_q[0].drain && digest_q.size() != 0) &&
				    $urandom_range(0, 99) >= send_idle_pct()) begin
					cur_req = req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= cur_req.data;
					s_tuser <= cur_req.mode;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		digest_beat_t exp_beat;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (digest_q.size() == 0) begin
					report_mismatch($sformatf("unexpected digest word %h", m_tdata[31:0]));
				end else begin
					exp_beat = digest_q.pop_front();
					if (m_tdata[31:0] !== exp_beat.word)
						report_mismatch($sformatf("digest_word %h, expected %h",
							m_tdata[31:0], exp_beat.word));
					if (m_tdata[34:32] !== exp_beat.idx)
						report_mismatch($sformatf("word_index %0d, expected %0d",
							m_tdata[34:32], exp_beat.idx));
					if (m_tlast !== exp_beat.last)
						report_mismatch($sformatf("last %b, expected %b",
							m_tlast, exp_beat.last));
				end
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (!hold_done && beats_seen >= 40) begin
				hold_done = 1'b1;
				hold_cnt = LONG_HOLD;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int rand_reqs;
		int msg_idx;
		int msg_len;
		int i;
		bit drain_next;

		hash_reset();

		// empty message, ignored code, "abc", byte extremes, back-to-back finish
		push_req(MODE_PARTIAL, 8'hff, 1'b0);
		push_req(MODE_FINISH, 8'ha5, 1'b0);
		push_req(MODE_UNUSED, 8'hff, 1'b0);
		push_req(MODE_ABSORB, 8'h61, 1'b0);
		push_req(MODE_ABSORB, 8'h62, 1'b0);
		push_req(MODE_ABSORB, 8'h63, 1'b0);
		push_req(MODE_PARTIAL, 8'h00, 1'b0);
		push_req(MODE_UNUSED, 8'h00, 1'b0);
		push_req(MODE_FINISH, 8'h5a, 1'b0);
		push_req(MODE_ABSORB, 8'h00, 1'b1);
		push_req(MODE_ABSORB, 8'hff, 1'b0);
		push_req(MODE_ABSORB, 8'h80, 1'b0);
		push_req(MODE_ABSORB, 8'h7f, 1'b0);
		push_req(MODE_FINISH, 8'hff, 1'b0);
		push_req(MODE_FINISH, 8'h00, 1'b0);

		rand_reqs = 0;
		msg_idx = 0;
		drain_next = 1'b1;
		while (rand_reqs < RANDOM_ITEMS) begin
			case (msg_idx)
				2:       msg_len = 55;
				5:       msg_len = 56;
				8:       msg_len = 67;
				default: msg_len = $urandom_range(0, 20);
			endcase
			for (i = 0; i < msg_len; i++) begin
				if ($urandom_range(0, 9) == 0) begin
					push_req(MODE_PARTIAL, 8'($urandom_range(0, 255)), drain_next);
					drain_next = 1'b0;
					rand_reqs++;
				end
				if ($urandom_range(0, 19) == 0) begin
					push_req(MODE_UNUSED, 8'($urandom_range(0, 255)), drain_next);
					drain_next = 1'b0;
				end
				push_req(MODE_ABSORB, 8'($urandom_range(0, 255)), drain_next);
				drain_next = 1'b0;
				rand_reqs++;
			end
			push_req(($urandom_range(0, 5) == 0) ? MODE_PARTIAL : MODE_FINISH,
				8'($urandom_range(0, 255)), drain_next);
			if ($urandom_range(0, 3) == 0)
				push_req(MODE_FINISH, 8'($urandom_range(0, 255)), 1'b0);
			rand_reqs++;
			msg_idx++;
			drain_next = (msg_idx % 6 == 0);
		end
		total_reqs = req_q.size();

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (req_q.size() > 0 || s_tvalid || digest_q.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (digest_q.size() > 0)
			report_mismatch($sformatf("%0d digest words never arrived", digest_q.size()));
		if (err_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[sim.f]
design/sha1h_pkg.sv
design/sha1h_ctrl.sv
design/sha1h_datapath.sv
design/sha1_stream_hasher.sv
test/sha1_stream_hasher_tb.sv
